### rtl/core/mfs_pkg.sv
// Shared types and constants for the SGD matrix factorization block.
// No dependencies.
package mfs_pkg;

    localparam int ADDR_W  = 22;  // covers 65536 rows x 64 elements
    localparam int ACC_W   = 40;  // dot product accumulator, Q.24
    localparam int TOTAL_W = 40;

    // func codes on the input channel
    localparam logic [2:0] FUNC_TRAIN = 3'd0;
    localparam logic [2:0] FUNC_WR_U  = 3'd1;
    localparam logic [2:0] FUNC_WR_I  = 3'd2;
    localparam logic [2:0] FUNC_RD_U  = 3'd3;
    localparam logic [2:0] FUNC_RD_I  = 3'd4;

    // classified command kinds
    localparam logic [2:0] K_NOP   = 3'd0;
    localparam logic [2:0] K_TRAIN = 3'd1;
    localparam logic [2:0] K_WR_U  = 3'd2;
    localparam logic [2:0] K_WR_I  = 3'd3;
    localparam logic [2:0] K_RD_U  = 3'd4;
    localparam logic [2:0] K_RD_I  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
    localparam logic [1:0] REG_REG_LAMBDA  = 2'd1;
    localparam logic [1:0] REG_MEAN_RATING = 2'd2;
    localparam logic [1:0] REG_REMOVE_MEAN = 2'd3;

    localparam logic [15:0] LEARN_RATE_RST = 16'd655;

    typedef struct packed {
        logic [2:0]         kind;
        logic [ADDR_W-1:0]  u_addr;
        logic [ADDR_W-1:0]  i_addr;
        logic [7:0]         rating;
        logic signed [15:0] value;
        logic               clear;
    } t_cmd;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] reg_lambda;
        logic [15:0] mean_rating;
        logic        remove_mean;
    } t_cfg;

endpackage

### rtl/core/mfs_if.sv
// Valid/ready channel interfaces for rating input and result output.
// No dependencies.
interface mfs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [11:0]        user_index;
    logic [11:0]        item_index;
    logic [7:0]         rating;
    logic [3:0]         elem_index;
    logic signed [15:0] elem_value;
    logic               clear_total;

    modport source(output valid, func, user_index, item_index, rating, elem_index,
                   elem_value, clear_total, input ready);
    modport sink(input valid, func, user_index, item_index, rating, elem_index,
                 elem_value, clear_total, output ready);
endinterface

interface mfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] error_value;
    logic signed [15:0] read_value;
    logic [39:0]        abs_error_total;

    modport source(output valid, error_value, read_value, abs_error_total, input ready);
    modport sink(input valid, error_value, read_value, abs_error_total, output ready);
endinterface

### rtl/core/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/mfs_front.sv
// Front end: accepts transactions, range-checks and classifies them,
// and queues commands in a two-entry FIFO. Uses mfs_pkg and mfs_in_if.
module mfs_front #(
    parameter int RANK      = 16,
    parameter int USER_ROWS = 4096,
    parameter int ITEM_ROWS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfs_in_if.sink        i_in,
    output mfs_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    logic          user_ok, item_ok, elem_ok;
    logic [mfs_pkg::ADDR_W-1:0] u_base, i_base, elem_off;
    mfs_pkg::t_cmd cmd_in;
    logic          push, pop;

    mfs_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_count;

    assign user_ok = {5'd0, i_in.user_index} < 17'(USER_ROWS);
    assign item_ok = {5'd0, i_in.item_index} < 17'(ITEM_ROWS);
    assign elem_ok = {3'd0, i_in.elem_index} < 7'(RANK);

    assign u_base = mfs_pkg::ADDR_W'(i_in.user_index) * mfs_pkg::ADDR_W'(RANK);
    assign i_base = mfs_pkg::ADDR_W'(i_in.item_index) * mfs_pkg::ADDR_W'(RANK);
    assign elem_off = (i_in.func == mfs_pkg::FUNC_TRAIN) ? '0
                                                         : mfs_pkg::ADDR_W'(i_in.elem_index);

    always_comb begin
        cmd_in.u_addr = u_base + elem_off;
        cmd_in.i_addr = i_base + elem_off;
        cmd_in.rating = i_in.rating;
        cmd_in.value  = i_in.elem_value;
        cmd_in.clear  = i_in.clear_total;
        cmd_in.kind   = mfs_pkg::K_NOP;
        case (i_in.func)
            mfs_pkg::FUNC_TRAIN: if (user_ok && item_ok) cmd_in.kind = mfs_pkg::K_TRAIN;
            mfs_pkg::FUNC_WR_U:  if (user_ok && elem_ok) cmd_in.kind = mfs_pkg::K_WR_U;
            mfs_pkg::FUNC_WR_I:  if (item_ok && elem_ok) cmd_in.kind = mfs_pkg::K_WR_I;
            mfs_pkg::FUNC_RD_U:  if (user_ok && elem_ok) cmd_in.kind = mfs_pkg::K_RD_U;
            mfs_pkg::FUNC_RD_I:  if (item_ok && elem_ok) cmd_in.kind = mfs_pkg::K_RD_I;
            default:             cmd_in.kind = mfs_pkg::K_NOP;
        endcase
    end

    assign i_in.ready  = (r_count != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue overfilled");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 2'd1) else $error("push lost");
    a_count_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_count == $past(r_count) - 2'd1) else $error("pop lost");

endmodule

### rtl/core/mfs_back.sv
// Back end: executes queued commands against the factor RAMs, runs the
// dot product and the row update pipeline, keeps the error total and
// holds the result register. Uses mfs_pkg, mfs_out_if and mfs_ram.
module mfs_back #(
    parameter int RANK      = 16,
    parameter int USER_ROWS = 4096,
    parameter int ITEM_ROWS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mfs_pkg::t_cfg i_cfg,
    input  mfs_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    mfs_out_if.source     o_out
);

    localparam int UAW = $clog2(USER_ROWS * RANK);
    localparam int IAW = $clog2(ITEM_ROWS * RANK);
    localparam int KW  = $clog2(RANK + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_DOT    = 3'd3;
    localparam logic [2:0] ST_ERR    = 3'd4;
    localparam logic [2:0] ST_TOT    = 3'd5;
    localparam logic [2:0] ST_UPD    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    function automatic logic signed [35:0] f_rnd12(input logic signed [47:0] x);
        logic signed [47:0] t;
        t = x + 48'sd2048;
        return $signed(t[47:12]);
    endfunction

    function automatic logic signed [32:0] f_rnd16(input logic signed [48:0] x);
        logic signed [48:0] t;
        t = x + 49'sd32768;
        return $signed(t[48:16]);
    endfunction

    // new w = sat16(w + round16(g - d))
    function automatic logic signed [15:0] f_step(input logic signed [15:0] w,
                                                  input logic signed [52:0] g,
                                                  input logic signed [32:0] d);
        logic signed [53:0] t;
        logic signed [38:0] s;
        t = 54'(g) - 54'(d) + 54'sd32768;
        s = 39'(w) + 39'($signed(t[53:16]));
        if (s > 39'sd32767) begin
            return 16'sh7fff;
        end else if (s < -39'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    logic [2:0]           r_state;
    mfs_pkg::t_cmd        r_cmd;
    logic [KW-1:0]        r_k, r_wu, r_wi;
    logic                 r_dv1, r_dv2;
    logic signed [31:0]   r_prod;
    logic signed [mfs_pkg::ACC_W-1:0] r_acc;
    logic signed [31:0]   r_err;
    logic signed [15:0]   r_rd;
    logic [mfs_pkg::TOTAL_W-1:0] r_total;
    logic [31:0]          r_lamlr;

    logic [7:0]           r_pv;
    logic signed [47:0]   r_m1, r_m3;
    logic signed [48:0]   r_m2, r_m4;
    logic signed [35:0]   r_pe1, r_pe2;
    logic signed [32:0]   r_d1, r_d1b, r_d2, r_d2b;
    logic signed [52:0]   r_g1, r_g2;
    logic signed [15:0]   r_u2, r_u3, r_u4, r_nu;
    logic signed [15:0]   r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;

    logic                 r_out_valid;
    logic signed [31:0]   r_out_err;
    logic signed [15:0]   r_out_rd;
    logic [mfs_pkg::TOTAL_W-1:0] r_out_total;

    logic [15:0]          u_rd, v_rd;
    logic signed [15:0]   u_q, v_q, nu, nv;
    logic                 u_we, i_we, issue, take;
    logic [mfs_pkg::ADDR_W-1:0] u_raddr, i_raddr, u_waddr, i_waddr;
    logic [15:0]          u_wdata, i_wdata;
    logic signed [40:0]   acc_rnd;
    logic [31:0]          err_abs;
    logic [mfs_pkg::TOTAL_W:0] tot_sum;
    logic signed [mfs_pkg::ACC_W-1:0] acc_init;

    assign u_q = $signed(u_rd);
    assign v_q = $signed(v_rd);

    assign take      = r_out_valid && o_out.ready;
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid && (!r_out_valid || o_out.ready);
    assign issue     = ((r_state == ST_DOT) || (r_state == ST_UPD)) && (r_k < KW'(RANK));

    assign nu = f_step(r_u4, r_g1, r_d1b);
    assign nv = f_step(r_v8, r_g2, r_d2b);

    // read addresses: single element in EXEC, row walk otherwise
    assign u_raddr = (r_state == ST_EXEC) ? r_cmd.u_addr
                                          : r_cmd.u_addr + mfs_pkg::ADDR_W'(r_k);
    assign i_raddr = (r_state == ST_EXEC) ? r_cmd.i_addr
                                          : r_cmd.i_addr + mfs_pkg::ADDR_W'(r_k);

    always_comb begin
        if (r_state == ST_EXEC) begin
            u_we    = (r_cmd.kind == mfs_pkg::K_WR_U);
            u_waddr = r_cmd.u_addr;
            u_wdata = r_cmd.value;
            i_we    = (r_cmd.kind == mfs_pkg::K_WR_I);
            i_waddr = r_cmd.i_addr;
            i_wdata = r_cmd.value;
        end else begin
            u_we    = r_pv[3];
            u_waddr = r_cmd.u_addr + mfs_pkg::ADDR_W'(r_wu);
            u_wdata = nu;
            i_we    = r_pv[7];
            i_waddr = r_cmd.i_addr + mfs_pkg::ADDR_W'(r_wi);
            i_wdata = nv;
        end
    end

    mfs_ram #(.WIDTH(16), .DEPTH(USER_ROWS * RANK)) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr[UAW-1:0]),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr[UAW-1:0]),
        .o_rdata (u_rd)
    );

    mfs_ram #(.WIDTH(16), .DEPTH(ITEM_ROWS * RANK)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr[IAW-1:0]),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr[IAW-1:0]),
        .o_rdata (v_rd)
    );

    // target = rating in Q.24, less the mean when enabled
    assign acc_init = $signed({8'd0, i_cmd.rating, 24'd0})
                    - (i_cfg.remove_mean ? $signed({8'd0, i_cfg.mean_rating, 16'd0})
                                         : '0);
    // accumulator magnitude stays well inside 32 bits after rounding
    assign acc_rnd = 41'(r_acc) + 41'sd2048;
    assign err_abs = r_err[31] ? 32'(-r_err) : 32'(r_err);
    assign tot_sum = {1'b0, r_total} + (mfs_pkg::TOTAL_W + 1)'(err_abs);

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_lamlr <= 32'(i_cfg.reg_lambda) * 32'(i_cfg.learn_rate);
        r_prod  <= u_q * v_q;
        // user element update
        r_m1  <= v_q * r_err;
        r_m2  <= $signed({1'b0, r_lamlr}) * u_q;
        r_u2  <= u_q;
        r_v2  <= v_q;
        r_pe1 <= f_rnd12(r_m1);
        r_d1  <= f_rnd16(r_m2);
        r_u3  <= r_u2;
        r_v3  <= r_v2;
        r_g1  <= $signed({1'b0, i_cfg.learn_rate}) * r_pe1;
        r_d1b <= r_d1;
        r_u4  <= r_u3;
        r_v4  <= r_v3;
        // item element update with the new user element
        r_nu  <= nu;
        r_v5  <= r_v4;
        r_m3  <= r_nu * r_err;
        r_m4  <= $signed({1'b0, r_lamlr}) * r_v5;
        r_v6  <= r_v5;
        r_pe2 <= f_rnd12(r_m3);
        r_d2  <= f_rnd16(r_m4);
        r_v7  <= r_v6;
        r_g2  <= $signed({1'b0, i_cfg.learn_rate}) * r_pe2;
        r_d2b <= r_d2;
        r_v8  <= r_v7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_wu        <= '0;
            r_wi        <= '0;
            r_dv1       <= 1'b0;
            r_dv2       <= 1'b0;
            r_pv        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dv1 <= (r_state == ST_DOT) && issue;
            r_dv2 <= r_dv1;
            r_pv  <= {r_pv[6:0], (r_state == ST_UPD) && issue};
            if (issue) r_k <= r_k + KW'(1);
            if (r_pv[3]) r_wu <= r_wu + KW'(1);
            if (r_pv[7]) r_wi <= r_wi + KW'(1);
            if (r_dv2) r_acc <= r_acc - 40'(r_prod);
            if (take) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_err <= '0;
                        r_rd  <= '0;
                        r_k   <= '0;
                        r_acc <= acc_init;
                        if (i_cmd.clear) r_total <= '0;
                        case (i_cmd.kind)
                            mfs_pkg::K_TRAIN: r_state <= ST_DOT;
                            mfs_pkg::K_NOP:   r_state <= ST_DONE;
                            default:          r_state <= ST_EXEC;
                        endcase
                    end
                end
                ST_EXEC: begin
                    if (r_cmd.kind == mfs_pkg::K_RD_U || r_cmd.kind == mfs_pkg::K_RD_I) begin
                        r_state <= ST_RDWAIT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_RDWAIT: begin
                    r_rd    <= (r_cmd.kind == mfs_pkg::K_RD_U) ? u_q : v_q;
                    r_state <= ST_DONE;
                end
                ST_DOT: begin
                    if (r_k == KW'(RANK) && !r_dv1 && !r_dv2) r_state <= ST_ERR;
                end
                ST_ERR: begin
                    r_err   <= 32'($signed(acc_rnd[40:12]));
                    r_state <= ST_TOT;
                end
                ST_TOT: begin
                    r_total <= tot_sum[mfs_pkg::TOTAL_W] ? '1 : tot_sum[mfs_pkg::TOTAL_W-1:0];
                    r_k     <= '0;
                    r_wu    <= '0;
                    r_wi    <= '0;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (r_k == KW'(RANK) && r_pv == '0) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_err   <= r_err;
                    r_out_rd    <= r_rd;
                    r_out_total <= r_total;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.error_value     = r_out_err;
    assign o_out.read_value      = r_out_rd;
    assign o_out.abs_error_total = r_out_total;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pv == '0 && !r_dv1 && !r_dv2))
        else $error("pipeline busy in idle");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid) else $error("result not posted");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(RANK)) else $error("element counter overran");
    a_wr_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[3] || r_pv[7]) |-> (r_state == ST_UPD)) else $error("stray row write");

endmodule

### rtl/core/matrix_factorization_sgd_update.sv
// Train: RANK element reads for the dot product, then an 8-stage update pipeline
//   streaming RANK elements. An element write passes EXEC and DONE, a read EXEC,
//   RDWAIT and DONE, and an ignored op DONE alone. The back end runs one transaction
//   at a time, popping only in idle while the result register is free or taken; the
//   two-entry front queue takes inputs meanwhile; each factor RAM has one read port.
// Reset (sync, active low): queue, sequencer, error total and result valid clear;
//   config returns to defaults; factor RAMs are not cleared.
module matrix_factorization_sgd_update #(
    parameter int RANK      = 16,
    parameter int USER_ROWS = 4096,
    parameter int ITEM_ROWS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfs_in_if.sink      i_in,
    mfs_out_if.source   o_out,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mfs_pkg::t_cfg r_cfg;
    mfs_pkg::t_cmd cmd;
    logic          cmd_valid, cmd_pop;
    logic          cfg_wr;

    // Config registers, one word each; writes land in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate  <= mfs_pkg::LEARN_RATE_RST;
            r_cfg.reg_lambda  <= '0;
            r_cfg.mean_rating <= '0;
            r_cfg.remove_mean <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mfs_pkg::REG_LEARN_RATE:  r_cfg.learn_rate  <= pwdata[15:0];
                mfs_pkg::REG_REG_LAMBDA:  r_cfg.reg_lambda  <= pwdata[15:0];
                mfs_pkg::REG_MEAN_RATING: r_cfg.mean_rating <= pwdata[15:0];
                mfs_pkg::REG_REMOVE_MEAN: r_cfg.remove_mean <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mfs_pkg::REG_LEARN_RATE:  prdata = {16'd0, r_cfg.learn_rate};
            mfs_pkg::REG_REG_LAMBDA:  prdata = {16'd0, r_cfg.reg_lambda};
            mfs_pkg::REG_MEAN_RATING: prdata = {16'd0, r_cfg.mean_rating};
            mfs_pkg::REG_REMOVE_MEAN: prdata = {31'd0, r_cfg.remove_mean};
            default:                  prdata = '0;
        endcase
    end

    // Front: classify and queue each transaction.
    mfs_front #(.RANK(RANK), .USER_ROWS(USER_ROWS), .ITEM_ROWS(ITEM_ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: factor tables, training sequencer and result register.
    mfs_back #(.RANK(RANK), .USER_ROWS(USER_ROWS), .ITEM_ROWS(ITEM_ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

### tb/tb_matrix_factorization_sgd_update.sv
// Testbench for matrix_factorization_sgd_update: directed table, then random traffic.
// Depends on mfs_pkg, mfs_if and the block's RTL.
module tb_matrix_factorization_sgd_update;

    localparam int RANK      = 16;
    localparam int USER_ROWS = 4096;
    localparam int ITEM_ROWS = 4096;
    localparam int RAND_ITEMS = 1150;
    localparam longint TOTAL_MAX = (64'd1 << 40) - 1;

    // Small working set so trains hit only rows that were loaded
    localparam int NUM_U = 6;
    localparam int NUM_I = 6;

    logic i_clk;
    logic i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mfs_in_if  in_ch();
    mfs_out_if out_ch();

    matrix_factorization_sgd_update #(
        .RANK(RANK), .USER_ROWS(USER_ROWS), .ITEM_ROWS(ITEM_ROWS)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [2:0]         func;
        logic [11:0]        user_index;
        logic [11:0]        item_index;
        logic [7:0]         rating;
        logic [3:0]         elem_index;
        logic signed [15:0] elem_value;
        logic               clear_total;
    } t_rating_txn;

    typedef struct packed {
        logic signed [31:0] error_value;
        logic signed [15:0] read_value;
        logic [39:0]        abs_error_total;
    } t_result;

    // Predictor state: factor tables, error total, config
    logic signed [15:0] uf [int];
    logic signed [15:0] vf [int];
    longint             err_total;
    logic [15:0]        cfg_lr;
    logic [15:0]        cfg_lambda;
    logic [15:0]        cfg_mean;
    logic               cfg_rm;

    t_result expected_results[$];
    int      fail_count;

    // Directed table; chk marks rows whose result is typed in
    typedef struct {
        t_rating_txn txn;
        bit          chk;
        t_result     res;
    } t_dir_row;
    t_dir_row dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint rnd_sh(longint x, int sh);
        return (x + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clip16(longint x);
        if (x > 32767) return 16'sd32767;
        if (x < -32768) return -16'sd32768;
        return x[15:0];
    endfunction

    // One SGD row update: w += lr*p*err - lambda*lr*w
    task automatic sgd_row(bit upd_user, int wrow, int prow, longint err, longint lamlr);
        int k;
        longint w, p, pe, g, d;
        for (k = 0; k < RANK; k++) begin
            w  = upd_user ? uf[wrow * RANK + k] : vf[wrow * RANK + k];
            p  = upd_user ? vf[prow * RANK + k] : uf[prow * RANK + k];
            pe = rnd_sh(p * err, 12);
            g  = longint'(cfg_lr) * pe;
            d  = rnd_sh(lamlr * w, 16);
            if (upd_user) uf[wrow * RANK + k] = clip16(w + rnd_sh(g - d, 16));
            else          vf[wrow * RANK + k] = clip16(w + rnd_sh(g - d, 16));
        end
    endtask

    task automatic predict_result(input t_rating_txn t, output t_result r);
        int ui, ii, ei, k;
        bit uok, iok, eok;
        longint acc, err, lamlr;
        ui = t.user_index; ii = t.item_index; ei = t.elem_index;
        uok = ui < USER_ROWS; iok = ii < ITEM_ROWS; eok = ei < RANK;
        r = '0;
        if (t.clear_total) err_total = 0;
        case (t.func)
            mfs_pkg::FUNC_TRAIN: if (uok && iok) begin
                acc = longint'(t.rating) <<< 24;
                if (cfg_rm) acc -= longint'(cfg_mean) <<< 16;
                for (k = 0; k < RANK; k++)
                    acc -= longint'(uf[ui * RANK + k]) * longint'(vf[ii * RANK + k]);
                err = rnd_sh(acc, 12);
                if (err > 64'sd2147483647) err = 64'sd2147483647;
                if (err < -64'sd2147483648) err = -64'sd2147483648;
                lamlr = longint'(cfg_lambda) * longint'(cfg_lr);
                sgd_row(1'b1, ui, ii, err, lamlr);
                sgd_row(1'b0, ii, ui, err, lamlr);
                err_total += (err < 0) ? -err : err;
                if (err_total > TOTAL_MAX) err_total = TOTAL_MAX;
                r.error_value = err[31:0];
            end
            mfs_pkg::FUNC_WR_U: if (uok && eok) uf[ui * RANK + ei] = t.elem_value;
            mfs_pkg::FUNC_WR_I: if (iok && eok) vf[ii * RANK + ei] = t.elem_value;
            mfs_pkg::FUNC_RD_U: if (uok && eok) r.read_value = uf[ui * RANK + ei];
            mfs_pkg::FUNC_RD_I: if (iok && eok) r.read_value = vf[ii * RANK + ei];
            default: ;
        endcase
        r.abs_error_total = err_total[39:0];
    endtask

    // Sender: bursts of random length with random gaps between them
    int burst_left;
    task automatic send_txn(t_rating_txn t);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : $urandom_range(0, 4))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        {in_ch.func, in_ch.user_index, in_ch.item_index, in_ch.rating,
         in_ch.elem_index, in_ch.elem_value, in_ch.clear_total} <= t;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        @(negedge i_clk);
    endtask

    // A transaction sent here is predicted just before it is driven, in send order
    task automatic push_txn(t_rating_txn t, bit chk, t_result typed);
        t_result r;
        predict_result(t, r);
        if (chk && r !== typed) begin
            $display("%0t table row disagrees with prediction: exp %h pred %h",
                     $time, typed, r);
            fail_count++;
        end
        expected_results.push_back(r);
        send_txn(t);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            mfs_pkg::REG_LEARN_RATE:  cfg_lr     = val[15:0];
            mfs_pkg::REG_REG_LAMBDA:  cfg_lambda = val[15:0];
            mfs_pkg::REG_MEAN_RATING: cfg_mean   = val[15:0];
            default:                  cfg_rm     = val[0];
        endcase
    endtask

    // Block is idle once nothing is outstanding and the latency has passed
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (2 * RANK + 20) @(negedge i_clk);
    endtask

    function automatic t_rating_txn mk(logic [2:0] f, int u, int i, int rt, int e, int v,
                                       bit clr);
        t_rating_txn t;
        t.func = f; t.user_index = 12'(u); t.item_index = 12'(i); t.rating = 8'(rt);
        t.elem_index = 4'(e); t.elem_value = 16'(v); t.clear_total = clr;
        return t;
    endfunction

    function automatic t_result res(longint e, int rv, longint tot);
        t_result r;
        r.error_value = 32'(e); r.read_value = 16'(rv); r.abs_error_total = 40'(tot);
        return r;
    endfunction

    task automatic add_row(t_rating_txn t, bit chk = 0, t_result r = '0);
        t_dir_row d;
        d.txn = t; d.chk = chk; d.res = r;
        dir_rows.push_back(d);
    endtask

    // Loads full rows for the working set
    task automatic load_rows(bit rand_vals);
        int r, k, v;
        for (r = 0; r < NUM_U; r++)
            for (k = 0; k < RANK; k++) begin
                v = rand_vals ? int'($signed(16'($urandom_range(0, 16'hFFFF)))) : 256;
                v = rand_vals ? (($urandom_range(0, 7) == 0) ? v : v / 16) : v;
                push_txn(mk(mfs_pkg::FUNC_WR_U, (r < NUM_U - 1) ? r : USER_ROWS - 1, 0, 0,
                            k, v, 0), 0, '0);
            end
        for (r = 0; r < NUM_I; r++)
            for (k = 0; k < RANK; k++) begin
                v = rand_vals ? int'($signed(16'($urandom_range(0, 16'hFFFF)))) : 256;
                v = rand_vals ? (($urandom_range(0, 7) == 0) ? v : v / 16) : v;
                push_txn(mk(mfs_pkg::FUNC_WR_I, 0, (r < NUM_I - 1) ? r : ITEM_ROWS - 1, 0,
                            k, v, 0), 0, '0);
            end
    endtask

    function automatic int pick_row(int n, int top);
        int r;
        r = $urandom_range(0, n - 1);
        return (r == n - 1) ? top - 1 : r;
    endfunction

    function automatic t_rating_txn rand_txn();
        t_rating_txn t;
        int sel;
        t = '0;
        t.user_index  = 12'(pick_row(NUM_U, USER_ROWS));
        t.item_index  = 12'(pick_row(NUM_I, ITEM_ROWS));
        t.rating      = 8'($urandom_range(0, 255));
        t.elem_index  = 4'($urandom_range(0, RANK - 1));
        t.elem_value  = 16'($urandom_range(0, 16'hFFFF));
        t.clear_total = ($urandom_range(0, 19) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 55)      t.func = mfs_pkg::FUNC_TRAIN;
        else if (sel < 67) t.func = mfs_pkg::FUNC_WR_U;
        else if (sel < 79) t.func = mfs_pkg::FUNC_WR_I;
        else if (sel < 87) t.func = mfs_pkg::FUNC_RD_U;
        else if (sel < 95) t.func = mfs_pkg::FUNC_RD_I;
        else               t.func = 3'($urandom_range(5, 7));
        // Write values mostly small so training stays out of saturation
        if (t.func inside {mfs_pkg::FUNC_WR_U, mfs_pkg::FUNC_WR_I} &&
            $urandom_range(0, 3) != 0)
            t.elem_value = 16'($signed(t.elem_value) / 16);
        return t;
    endfunction

    // Receiver: stalls on its own pattern, with quiet stretches
    initial begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            phase++;
            if ((phase / 300) % 3 == 0) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 9) < 6);
        end
    end

    // Scoreboard on the result channel
    always @(posedge i_clk) begin
        t_result act, exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            act.error_value     = out_ch.error_value;
            act.read_value      = out_ch.read_value;
            act.abs_error_total = out_ch.abs_error_total;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, act);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (act.error_value !== exp_r.error_value) begin
                    $display("%0t error_value exp %0d act %0d", $time,
                             exp_r.error_value, act.error_value);
                    fail_count++;
                end
                if (act.read_value !== exp_r.read_value) begin
                    $display("%0t read_value exp %0d act %0d", $time,
                             exp_r.read_value, act.read_value);
                    fail_count++;
                end
                if (act.abs_error_total !== exp_r.abs_error_total) begin
                    $display("%0t abs_error_total exp %0d act %0d", $time,
                             exp_r.abs_error_total, act.abs_error_total);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int n, ph;
        fail_count = 0; burst_left = 0;
        err_total = 0; cfg_lr = mfs_pkg::LEARN_RATE_RST; cfg_lambda = 0; cfg_mean = 0;
        cfg_rm = 0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0;
        {in_ch.func, in_ch.user_index, in_ch.item_index, in_ch.rating,
         in_ch.elem_index, in_ch.elem_value, in_ch.clear_total} = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: element extremes, ignored cases, then trains on loaded rows
        add_row(mk(mfs_pkg::FUNC_WR_U, 0, 0, 0, 0, -32768, 0), 1, res(0, 0, 0));
        add_row(mk(mfs_pkg::FUNC_RD_U, 0, 0, 0, 0, 0, 0), 1, res(0, -32768, 0));
        add_row(mk(mfs_pkg::FUNC_WR_I, 0, 4095, 0, 15, 32767, 0), 1, res(0, 0, 0));
        add_row(mk(mfs_pkg::FUNC_RD_I, 0, 4095, 0, 15, 0, 0), 1, res(0, 32767, 0));
        add_row(mk(3'd5, 4095, 4095, 255, 15, -1, 1), 1, res(0, 0, 0));
        add_row(mk(3'd6, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0));
        add_row(mk(3'd7, 1, 1, 1, 1, 1, 0), 1, res(0, 0, 0));
        foreach (dir_rows[j]) push_txn(dir_rows[j].txn, dir_rows[j].chk, dir_rows[j].res);
        load_rows(0);
        // Rows all 1/16: dot = 16*(1/256) = 1/16, so error = rating - 1/16
        push_txn(mk(mfs_pkg::FUNC_TRAIN, 0, 0, 0, 0, 0, 0), 1, res(-256, 0, 256));
        push_txn(mk(mfs_pkg::FUNC_TRAIN, 4095, 4095, 255, 0, 0, 1), 0, '0);
        push_txn(mk(mfs_pkg::FUNC_TRAIN, 1, 2, 3, 15, -1, 0), 0, '0);
        push_txn(mk(mfs_pkg::FUNC_RD_U, 0, 0, 0, 7, 0, 0), 0, '0);
        push_txn(mk(mfs_pkg::FUNC_RD_I, 0, 0, 0, 7, 0, 0), 0, '0);
        push_txn(mk(mfs_pkg::FUNC_RD_U, 4095, 4095, 0, 0, 0, 0), 0, '0);
        drain();

        // Random phases across several register settings, extremes among them
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    apb_write(mfs_pkg::REG_LEARN_RATE, 655);
                    apb_write(mfs_pkg::REG_REG_LAMBDA, 0);
                    apb_write(mfs_pkg::REG_MEAN_RATING, 0);
                    apb_write(mfs_pkg::REG_REMOVE_MEAN, 0);
                end
                1: begin
                    apb_write(mfs_pkg::REG_LEARN_RATE, 16'hFFFF);
                    apb_write(mfs_pkg::REG_REG_LAMBDA, 16'hFFFF);
                    apb_write(mfs_pkg::REG_MEAN_RATING, 16'hFFFF);
                    apb_write(mfs_pkg::REG_REMOVE_MEAN, 1);
                end
                2: begin
                    apb_write(mfs_pkg::REG_LEARN_RATE, 0);
                    apb_write(mfs_pkg::REG_REG_LAMBDA, 0);
                    apb_write(mfs_pkg::REG_MEAN_RATING, 0);
                    apb_write(mfs_pkg::REG_REMOVE_MEAN, 1);
                end
                default: begin
                    apb_write(mfs_pkg::REG_LEARN_RATE, $urandom_range(0, 16'hFFFF));
                    apb_write(mfs_pkg::REG_REG_LAMBDA, $urandom_range(0, 16'hFFFF));
                    apb_write(mfs_pkg::REG_MEAN_RATING, $urandom_range(0, 16'hFFFF));
                    apb_write(mfs_pkg::REG_REMOVE_MEAN, $urandom_range(0, 1));
                end
            endcase
            load_rows(1);
            for (n = 0; n < RAND_ITEMS / 5 - 2 * NUM_U * RANK; n++)
                push_txn(rand_txn(), 0, '0);
            drain();
        end

        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

### filelist.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_if.sv
rtl/core/mfs_ram.sv
rtl/core/mfs_front.sv
rtl/core/mfs_back.sv
rtl/core/matrix_factorization_sgd_update.sv
tb/tb_matrix_factorization_sgd_update.sv
